>>> hdl/emc_pkg.sv
package emc_pkg;

  // field widths
  localparam int MILLIS_W = 42;
  localparam int SECS_W   = 32;
  localparam int DAYS_W   = 16;
  localparam int SOD_W    = 17;
  localparam int DOE_W    = 18;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DOM_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;

  // pipeline depths: seconds and day split, then the date section
  localparam int FRONT_LAT = 6;
  localparam int DATE_LAT  = 7;
  localparam int TOP_LAT   = FRONT_LAT + DATE_LAT;

  // reciprocals for exact division by constants, ceil(2^(n+l)/d)
  // upper millis bits (19 bits) by 125, shift 26
  localparam logic [19:0] RCP_MS_HI = 20'(((64'd1 << 26) + 64'd124) / 64'd125);
  // remainder and lower millis bits (27 bits) by 125, shift 34
  localparam logic [27:0] RCP_MS_LO = 28'(((64'd1 << 34) + 64'd124) / 64'd125);
  // seconds / 128 (25 bits) by 675, shift 35
  localparam logic [25:0] RCP_DAY   = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
  // second of day / 16 (13 bits) by 225, shift 21
  localparam logic [13:0] RCP_HOUR  = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
  // second of hour / 4 (10 bits) by 15, shift 14
  localparam logic [10:0] RCP_MIN   = 11'(((64'd1 << 14) + 64'd14) / 64'd15);
  // day of era (18 bits) by 1460, shift 29
  localparam logic [18:0] RCP_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  // day of era adjusted (18 bits) by 365, shift 27
  localparam logic [18:0] RCP_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  // 5 * day of year + 2 (11 bits) by 153, shift 19
  localparam logic [11:0] RCP_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  // calendar constants
  localparam int SECS_PER_DAY   = 86400;
  localparam int DAYS_TO_EPOCH  = 719468;
  localparam int DAYS_PER_ERA   = 146097;
  // day numbers at which eras four and five begin
  localparam int ERA4_START     = 4 * DAYS_PER_ERA;
  localparam int ERA5_START     = 5 * DAYS_PER_ERA;

  // time of day carried alongside the date section
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_t;

endpackage

>>> hdl/emc_date.sv
module emc_date import emc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [DAYS_W-1:0]  days,
  output logic               out_valid,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [DOM_W-1:0]   day_of_month
);

  // first day of each March-based month, (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  logic [DATE_LAT-1:0] vld;

  logic [DOE_W-1:0] doe1, doe2, doe3, doe4;
  logic             era1, era2, era3, era4, era5, era6;
  logic [36:0]      pa2;
  logic [2:0]       quad2;
  logic             last2;
  logic [DOE_W-1:0] t3;
  logic [36:0]      py4;
  logic [8:0]       yoe5, yoe6;
  logic [8:0]       doy5, doy6;
  logic [22:0]      pm6;

  logic [19:0]      z;
  logic             era_hi;
  logic [DOE_W-1:0] doe_c;
  logic [8:0]       yoe_c;
  logic [1:0]       cent_c;
  logic [DOE_W-1:0] yoe_days;
  logic [10:0]      x_c;
  logic [3:0]       mp_c;
  logic [3:0]       month_c;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DATE_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[DATE_LAT-1];

  // shift to 0000-03-01; only eras four and five are reachable from 32-bit seconds
  always_comb begin
    z      = 20'(days) + 20'(DAYS_TO_EPOCH);
    era_hi = (z >= 20'(ERA5_START));
    doe_c  = era_hi ? 18'(z - 20'(ERA5_START)) : 18'(z - 20'(ERA4_START));
  end

  // year of era, year-day offset and month index
  always_comb begin
    yoe_c = py4[35:27];
    if (yoe_c >= 9'd300) begin
      cent_c = 2'd3;
    end else if (yoe_c >= 9'd200) begin
      cent_c = 2'd2;
    end else if (yoe_c >= 9'd100) begin
      cent_c = 2'd1;
    end else begin
      cent_c = 2'd0;
    end
    yoe_days = 18'(yoe_c) * 18'(365) + 18'(yoe_c[8:2]) - 18'(cent_c);
    x_c      = 11'({doy5, 2'b00}) + 11'(doy5) + 11'd2;
    mp_c     = pm6[22:19];
    month_c  = (mp_c < 4'd10) ? mp_c + 4'd3 : mp_c - 4'd9;
  end

  // date stages
  always_ff @(posedge clk) begin
    // stage 1: day of era
    doe1  <= doe_c;
    era1  <= era_hi;
    // stage 2: leap corrections
    pa2   <= 37'(doe1) * 37'(RCP_1460);
    if (doe1 >= 18'(4 * 36524)) begin
      quad2 <= 3'd4;
    end else if (doe1 >= 18'(3 * 36524)) begin
      quad2 <= 3'd3;
    end else if (doe1 >= 18'(2 * 36524)) begin
      quad2 <= 3'd2;
    end else if (doe1 >= 18'(36524)) begin
      quad2 <= 3'd1;
    end else begin
      quad2 <= 3'd0;
    end
    last2 <= (doe1 == 18'(DAYS_PER_ERA - 1));
    doe2  <= doe1;
    era2  <= era1;
    // stage 3: days in 365-day units
    t3    <= doe2 - 18'(pa2[36:29]) + 18'(quad2) - 18'(last2);
    doe3  <= doe2;
    era3  <= era2;
    // stage 4: year of era
    py4   <= 37'(t3) * 37'(RCP_365);
    doe4  <= doe3;
    era4  <= era3;
    // stage 5: day of March-based year
    yoe5  <= yoe_c;
    doy5  <= 9'(doe4 - yoe_days);
    era5  <= era4;
    // stage 6: month index
    pm6   <= 23'(x_c) * 23'(RCP_153);
    doy6  <= doy5;
    yoe6  <= yoe5;
    era6  <= era5;
    // stage 7: calendar fields
    year         <= 12'(yoe6) + (era6 ? 12'd2000 : 12'd1600) + 12'(mp_c >= 4'd10);
    month        <= month_c;
    day_of_month <= 5'(doy6 - month_start(mp_c) + 9'd1);
  end

`ifndef NO_ASSERTIONS
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##DATE_LAT out_valid)
    else $error("date section lost a beat");

  a_month: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1) && (month <= 4'd12))
    else $error("month out of range");

  a_year: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (year >= 12'd1970) && (year <= 12'd2106)
      && (day_of_month >= 5'd1) && (day_of_month <= 5'd31))
    else $error("year or day out of range");
`endif

endmodule

>>> hdl/epoch_millis_to_calendar_top.sv
// channel  | handshake    | fields
// ---------+--------------+-----------------------------------------------
// input    | start / busy | unix_millis
// result   | done         | year, month, day_of_month, hour, minute, second
//
// one beat in per cycle; results leave in the order of their start beats
// the pipeline is a chain of reciprocal multipliers: six stages to reach
// seconds, day number and second of day, seven more through the date section
// busy is held low: the pipeline never stalls and the receiver cannot stall
// synchronous reset clears the valid bits only; payload registers are not reset
module epoch_millis_to_calendar_top import emc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MILLIS_W-1:0] unix_millis,
  output logic                done,
  output logic [YEAR_W-1:0]   year,
  output logic [MONTH_W-1:0]  month,
  output logic [DOM_W-1:0]    day_of_month,
  output logic [HOUR_W-1:0]   hour,
  output logic [MIN_W-1:0]    minute,
  output logic [SEC_W-1:0]    second
);

  localparam int TOD_DLY = DATE_LAT - 4;

  logic [FRONT_LAT-1:0] vld;

  logic [38:0]        p1;
  logic [18:0]        hi1;
  logic [19:0]        lo1;
  logic [12:0]        qh2, qh3;
  logic [26:0]        n2;
  logic [54:0]        p3;
  logic [SECS_W-1:0]  secs4, secs5;
  logic [50:0]        p5;
  logic [DAYS_W-1:0]  days6;
  logic [SOD_W-1:0]   sod6, sod7;
  logic [26:0]        p7;
  logic [HOUR_W-1:0]  hr8, hr9;
  logic [11:0]        rem8, rem9;
  logic [20:0]        p9;
  tod_t               tod10;
  tod_t               tod_dly [TOD_DLY];

  logic [12:0]        qh_c;
  logic [18:0]        rh_c;
  logic [DAYS_W-1:0]  days_c;
  logic [HOUR_W-1:0]  hr_c;
  logic [MIN_W-1:0]   mn_c;

  assign busy = 1'b0;

  // valid bits of the front section
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LAT-2:0], start & ~busy};
    end
  end

  // quotients, and the remainder of the upper half, taken from the registered products
  always_comb begin
    qh_c   = p1[38:26];
    rh_c   = hi1 - 19'(qh_c) * 19'(125);
    days_c = p5[50:35];
    hr_c   = p7[25:21];
    mn_c   = p9[19:14];
  end

  // millis to seconds (divide by 8, then by 125 in two halves), then day split
  always_ff @(posedge clk) begin
    p1    <= 39'(unix_millis[41:23]) * 39'(RCP_MS_HI);
    hi1   <= unix_millis[41:23];
    lo1   <= unix_millis[22:3];
    qh2   <= qh_c;
    n2    <= {rh_c[6:0], lo1};
    p3    <= 55'(n2) * 55'(RCP_MS_LO);
    qh3   <= qh2;
    secs4 <= {qh3[11:0], p3[53:34]};
    p5    <= 51'(secs4[31:7]) * 51'(RCP_DAY);
    secs5 <= secs4;
    days6 <= days_c;
    sod6  <= 17'(secs5 - 32'(days_c) * 32'(SECS_PER_DAY));
  end

  // time of day
  always_ff @(posedge clk) begin
    p7           <= 27'(sod6[16:4]) * 27'(RCP_HOUR);
    sod7         <= sod6;
    hr8          <= hr_c;
    rem8         <= 12'(sod7 - 17'(hr_c) * 17'(3600));
    p9           <= 21'(rem8[11:2]) * 21'(RCP_MIN);
    rem9         <= rem8;
    hr9          <= hr8;
    tod10.hour   <= hr9;
    tod10.minute <= mn_c;
    tod10.second <= 6'(rem9 - 12'(mn_c) * 12'(60));
  end

  // hold the time of day until the date comes out
  always_ff @(posedge clk) begin
    tod_dly[0] <= tod10;
    for (int i = 1; i < TOD_DLY; i++) begin
      tod_dly[i] <= tod_dly[i-1];
    end
  end

  // day number to calendar date
  emc_date u_date (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (vld[FRONT_LAT-1]),
    .days         (days6),
    .out_valid    (done),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month)
  );

  assign hour   = tod_dly[TOD_DLY-1].hour;
  assign minute = tod_dly[TOD_DLY-1].minute;
  assign second = tod_dly[TOD_DLY-1].second;

`ifndef NO_ASSERTIONS
  a_beat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##TOP_LAT done)
    else $error("accepted beat gave no result");

  a_tod: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
    else $error("time of day out of range");

  a_feb: assert property (@(posedge clk) disable iff (rst)
    done && (month == 4'd2) |-> (day_of_month <= 5'd29))
    else $error("february day out of range");
`endif

endmodule

>>> bench/epoch_millis_to_calendar_checker.sv
module epoch_millis_to_calendar_checker import emc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [MILLIS_W-1:0] unix_millis,
  input  logic                done,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DOM_W-1:0]    day_of_month,
  input  logic [HOUR_W-1:0]   hour,
  input  logic [MIN_W-1:0]    minute,
  input  logic [SEC_W-1:0]    second,
  output int                  mismatches,
  output int                  outstanding
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } calendar_t;

  // dates still owed by the block, oldest first
  calendar_t calendar_q[$];
  int fail_total = 0;

  // utc calendar fields of a millisecond timestamp, march-based year per era
  function automatic calendar_t civil_from_millis(logic [MILLIS_W-1:0] ms);
    logic [63:0] whole_secs;
    logic [31:0] secs, days, z, era, doe, yoe, doy, mp, dom, mon, yr;
    calendar_t c;
    // seconds count keeps its low 32 bits only
    whole_secs = 64'(ms) / 64'd1000;
    secs = whole_secs[31:0];
    days = secs / 32'(SECS_PER_DAY);
    z    = days + 32'(DAYS_TO_EPOCH);
    era  = z / 32'(DAYS_PER_ERA);
    doe  = z - era * 32'(DAYS_PER_ERA);
    yoe  = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
    doy  = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
    mp   = (32'd5 * doy + 32'd2) / 32'd153;
    dom  = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
    mon  = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
    yr   = yoe + era * 32'd400 + ((mon <= 32'd2) ? 32'd1 : 32'd0);
    c.year         = yr[YEAR_W-1:0];
    c.month        = mon[MONTH_W-1:0];
    c.day_of_month = dom[DOM_W-1:0];
    c.hour         = HOUR_W'((secs / 32'd3600) % 32'd24);
    c.minute       = MIN_W'((secs / 32'd60) % 32'd60);
    c.second       = SEC_W'(secs % 32'd60);
    return c;
  endfunction

  // record each input beat, compare each result beat with the oldest date
  always @(posedge clk) begin
    calendar_t want, got;
    if (rst) begin
      calendar_q.delete();
      fail_total = 0;
    end else begin
      if (start && !busy) begin
        calendar_q.push_back(civil_from_millis(unix_millis));
      end
      if (done) begin
        got = '{year, month, day_of_month, hour, minute, second};
        if (calendar_q.size() == 0) begin
          if (fail_total < REPORT_LIMIT) begin
            $display("unexpected result beat: %0d-%0d-%0d %0d:%0d:%0d", got.year,
                     got.month, got.day_of_month, got.hour, got.minute, got.second);
          end
          fail_total++;
        end else begin
          want = calendar_q.pop_front();
          if (want.year !== got.year || want.month !== got.month ||
              want.day_of_month !== got.day_of_month || want.hour !== got.hour ||
              want.minute !== got.minute || want.second !== got.second) begin
            if (fail_total < REPORT_LIMIT) begin
              $display("date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                       want.year, want.month, want.day_of_month, want.hour, want.minute,
                       want.second, got.year, got.month, got.day_of_month, got.hour,
                       got.minute, got.second);
            end
            fail_total++;
          end
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= calendar_q.size();
  end

endmodule

>>> bench/tb_epoch_millis_to_calendar_top.sv
module tb_epoch_millis_to_calendar_top;
  import emc_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_BEATS = 480;
  localparam int MAX_GAP      = 14;
  localparam int IDLE_LIMIT   = 500;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [MILLIS_W-1:0] unix_millis = '0;
  logic                busy;
  logic                done;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DOM_W-1:0]    day_of_month;
  logic [HOUR_W-1:0]   hour;
  logic [MIN_W-1:0]    minute;
  logic [SEC_W-1:0]    second;
  int                  mismatches;
  int                  outstanding;
  int                  idle_cycles = 0;
  int                  burst_left = 0;

  // epoch, second and day edges, leap days, era start, 2100, wrap of the seconds count
  longint unsigned directed_ms [21] = '{
    64'd0, 64'd999, 64'd1000, 64'd59999, 64'd86399999, 64'd86400000,
    64'd68169600000, 64'd68255999999, 64'd946684799999, 64'd946684800000,
    64'd951782400000, 64'd951868800000, 64'd4107456000000, 64'd4107542400000,
    64'd4294967295000, 64'd4294967295999, 64'd4294967296000, 64'd4294967296999,
    64'd4398046511103, 64'd2199023255552, 64'd1234567890123
  };

  always #4 clk = ~clk;

  epoch_millis_to_calendar_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .unix_millis  (unix_millis),
    .done         (done),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  epoch_millis_to_calendar_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .unix_millis  (unix_millis),
    .done         (done),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // idle cycles after a beat, with occasional back-to-back bursts
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // timestamp mix: whole field, valid range, day edges, near the wrap, small values
  function automatic logic [MILLIS_W-1:0] pick_millis();
    longint unsigned secs, ms;
    case ($urandom_range(0, 9))
      0, 1: ms = (64'($urandom_range(0, 1023)) << 32) | 64'($urandom);
      2, 3, 4, 5: begin
        secs = 64'($urandom);
        ms   = secs * 64'd1000 + 64'($urandom_range(0, 999));
      end
      6, 7: begin
        secs = 64'($urandom_range(0, 49710)) * 64'd86400;
        case ($urandom_range(0, 3))
          0: secs = secs + 64'd1;
          1: secs = secs + 64'd86399;
          2: secs = secs + 64'd86398;
          default: secs = secs;
        endcase
        ms = secs * 64'd1000 + ($urandom_range(0, 1) ? 64'd999 : 64'd0);
      end
      8: ms = 64'd4294967286000 + 64'($urandom_range(0, 20000));
      default: ms = 64'($urandom_range(0, 200000000));
    endcase
    return ms[MILLIS_W-1:0];
  endfunction

  // present one beat, hold until accepted, then idle for a drawn gap
  task automatic send_beat(input logic [MILLIS_W-1:0] ms);
    int gap;
    start       <= 1'b1;
    unix_millis <= ms;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every owed date has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // stimulus and verdict
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_ms[i]) send_beat(directed_ms[i][MILLIS_W-1:0]);
    drain();
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 2) drain();
      send_beat(pick_millis());
    end
    drain();
    repeat (TOP_LAT + 4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
hdl/emc_pkg.sv
hdl/emc_date.sv
hdl/epoch_millis_to_calendar_top.sv
bench/epoch_millis_to_calendar_checker.sv
bench/tb_epoch_millis_to_calendar_top.sv
